// ----- hdl/rbw_pkg.sv -----
// Package for the RGB888 to BGR565 window writer.
// Holds the word types, register indexes, word phase codes and color masks.
// No dependencies.
`default_nettype none

package rbw_pkg;

  localparam int unsigned COORD_W = 9;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COUNT_W = 19;

  localparam logic [WORD_W-1:0] RED_MASK   = 16'h001F;
  localparam logic [WORD_W-1:0] GREEN_MASK = 16'h07E0;
  localparam logic [WORD_W-1:0] BLUE_MASK  = 16'hF800;

  localparam logic [COORD_W-1:0] RST_START_X = 9'd0;
  localparam logic [COORD_W-1:0] RST_START_Y = 9'd0;
  localparam logic [COORD_W-1:0] RST_END_X   = 9'd239;
  localparam logic [COORD_W-1:0] RST_END_Y   = 9'd319;

  typedef enum logic [1:0] {
    REG_WIN_START_X = 2'd0,
    REG_WIN_START_Y = 2'd1,
    REG_WIN_END_X   = 2'd2,
    REG_WIN_END_Y   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } word_phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] pic_word;
    logic              frame_start;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [WORD_W-1:0]  pix_color;
    logic               pix_last;
  } out_pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COUNT_W-1:0] total;
  } win_cfg_t;

  // Pixel count of a window rounded down to even; zero for a reversed window.
  function automatic logic [COUNT_W-1:0] pixel_total(
    input logic [COORD_W-1:0] sx,
    input logic [COORD_W-1:0] sy,
    input logic [COORD_W-1:0] ex,
    input logic [COORD_W-1:0] ey
  );
    logic [COORD_W:0]     w;
    logic [COORD_W:0]     h;
    logic [2*COORD_W+1:0] prod;
    begin
      w    = {1'b0, ex} - {1'b0, sx} + {{COORD_W{1'b0}}, 1'b1};
      h    = {1'b0, ey} - {1'b0, sy} + {{COORD_W{1'b0}}, 1'b1};
      prod = w * h;
      if ((ex < sx) || (ey < sy)) begin
        pixel_total = '0;
      end else begin
        pixel_total = {prod[COUNT_W-1:1], 1'b0};
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rgb888_to_bgr565_window_writer.sv -----
// Top level of the RGB888 to BGR565 window writer.
// Depends on rbw_pkg, rbw_cfg, rbw_core and rbw_out_reg.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one 16-bit
// word of a little-endian RGB888 byte stream per transfer, plus a frame_start
// flag that restarts the picture before that word is used. Every group of
// three words yields two BGR565 pixels on the output channel (out_valid,
// out_stall, out_data), each with its window column and row. Rows advance
// first; past the window's last row the column advances and the row reloads.
// The final pixel of a picture carries pix_last, and once the even pixel total
// of the window has been sent, further words are taken and dropped until the
// next frame_start.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_wdata)
// writes the four window registers; cfg_ready is always high. Write it only
// while no word is in flight.
// A pixel is in the output register the cycle after its word is taken.
// Throughput is one word per cycle while not stalled, set by the single
// output register. When the receiver stalls with a pixel waiting, in_stall is
// raised in the same cycle and the pixel holds. Synchronous reset clears the
// word phase, position, count and output valid, and loads the default window.
`default_nettype none

module rgb888_to_bgr565_window_writer
  import rbw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_word_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_pix_t                out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [COORD_W-1:0] cfg_wdata
);

  win_cfg_t win;
  logic     accept;
  logic     pix_emit;
  out_pix_t pix;
  logic     full_stalled;

  // A word is taken whenever the output register is empty or draining.
  assign in_stall = full_stalled;
  assign accept   = in_valid && !in_stall;

  rbw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .win       (win)
  );

  rbw_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .win      (win),
    .pix_emit (pix_emit),
    .pix      (pix)
  );

  rbw_out_reg u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept && pix_emit),
    .load_pix     (pix),
    .full_stalled (full_stalled),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

// ----- hdl/rbw_cfg.sv -----
// Window registers and the even pixel total of the window.
// Depends on rbw_pkg.
`default_nettype none

module rbw_cfg
  import rbw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [COORD_W-1:0] cfg_wdata,
  output win_cfg_t                win
);

  logic [COORD_W-1:0] start_x_r, start_x_nxt;
  logic [COORD_W-1:0] start_y_r, start_y_nxt;
  logic [COORD_W-1:0] end_x_r, end_x_nxt;
  logic [COORD_W-1:0] end_y_r, end_y_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  cfg_idx_t           idx;

  assign cfg_ready = 1'b1;
  assign idx       = cfg_idx_t'(cfg_index);

  always_comb begin
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    end_x_nxt   = end_x_r;
    end_y_nxt   = end_y_r;
    if (cfg_valid && cfg_ready) begin
      unique case (idx)
        REG_WIN_START_X: start_x_nxt = cfg_wdata;
        REG_WIN_START_Y: start_y_nxt = cfg_wdata;
        REG_WIN_END_X:   end_x_nxt   = cfg_wdata;
        REG_WIN_END_Y:   end_y_nxt   = cfg_wdata;
        default:         start_x_nxt = start_x_r;
      endcase
    end
    // The total is kept in step with the registers so it is valid the cycle after a write.
    total_nxt = pixel_total(start_x_nxt, start_y_nxt, end_x_nxt, end_y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= RST_START_X;
      start_y_r <= RST_START_Y;
      end_x_r   <= RST_END_X;
      end_y_r   <= RST_END_Y;
      total_r   <= pixel_total(RST_START_X, RST_START_Y, RST_END_X, RST_END_Y);
    end else begin
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      end_x_r   <= end_x_nxt;
      end_y_r   <= end_y_nxt;
      total_r   <= total_nxt;
    end
  end

  assign win.start_x = start_x_r;
  assign win.start_y = start_y_r;
  assign win.end_x   = end_x_r;
  assign win.end_y   = end_y_r;
  assign win.total   = total_r;

endmodule

`default_nettype wire

// ----- hdl/rbw_core.sv -----
// Word unpacking, color repacking and window walk for each accepted word.
// Depends on rbw_pkg.
`default_nettype none

module rbw_core
  import rbw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_word_t in_data,
  input  wire win_cfg_t win,
  output logic          pix_emit,
  output out_pix_t      pix
);

  word_phase_t        phase_r, phase_nxt, phase_eff;
  logic [WORD_W-1:0]  held1_r, held1_nxt;
  logic [WORD_W-1:0]  held2_r, held2_nxt;
  logic [COORD_W-1:0] col_r, col_nxt, col_eff;
  logic [COORD_W-1:0] row_r, row_nxt, row_eff, row_inc;
  logic [COUNT_W-1:0] sent_r, sent_nxt, sent_eff, sent_inc;
  logic               done;
  logic [WORD_W-1:0]  word;

  always_comb begin
    word      = in_data.pic_word;
    phase_eff = in_data.frame_start ? PH_FIRST : phase_r;
    col_eff   = in_data.frame_start ? win.start_x : col_r;
    row_eff   = in_data.frame_start ? win.start_y : row_r;
    sent_eff  = in_data.frame_start ? '0 : sent_r;
    done      = (sent_eff >= win.total);
    sent_inc  = sent_eff + {{(COUNT_W-1){1'b0}}, 1'b1};
    row_inc   = row_eff + {{(COORD_W-1){1'b0}}, 1'b1};

    phase_nxt     = phase_eff;
    held1_nxt     = held1_r;
    held2_nxt     = held2_r;
    col_nxt       = col_eff;
    row_nxt       = row_eff;
    sent_nxt      = sent_eff;
    pix_emit      = 1'b0;
    pix.pix_x     = col_eff;
    pix.pix_y     = row_eff;
    pix.pix_last  = (sent_inc == win.total);
    pix.pix_color = '0;

    if (!done) begin
      unique case (phase_eff)
        PH_SECOND: begin
          held2_nxt     = word;
          phase_nxt     = PH_THIRD;
          pix_emit      = 1'b1;
          pix.pix_color = ((held1_r >> 3) & RED_MASK) | ((held1_r >> 5) & GREEN_MASK)
                        | ((word << 8) & BLUE_MASK);
        end
        PH_THIRD: begin
          phase_nxt     = PH_FIRST;
          pix_emit      = 1'b1;
          pix.pix_color = ((held2_r >> 11) & RED_MASK) | ((word << 3) & GREEN_MASK)
                        | (word & BLUE_MASK);
        end
        default: begin
          // The unused phase code behaves as the first word of a group.
          held1_nxt = word;
          phase_nxt = PH_SECOND;
        end
      endcase
    end

    if (pix_emit) begin
      sent_nxt = sent_inc;
      if (row_inc > win.end_y) begin
        col_nxt = col_eff + {{(COORD_W-1){1'b0}}, 1'b1};
        row_nxt = win.start_y;
      end else begin
        row_nxt = row_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      held1_r <= '0;
      held2_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      sent_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held1_r <= held1_nxt;
      held2_r <= held2_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sent_r  <= sent_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rbw_out_reg.sv -----
// Result register between the pixel logic and the output channel.
// Depends on rbw_pkg.
`default_nettype none

module rbw_out_reg
  import rbw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire out_pix_t load_pix,
  output logic          full_stalled,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_pix_t      out_data
);

  logic     valid_r, valid_nxt;
  out_pix_t data_r;

  assign full_stalled = valid_r && out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_pix;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire
